[rtl/core/edbd_pkg.sv]
// ----------------------------------------------------------------------------
// edbd_pkg: shared definitions for the error diffusion binary dither
// Field widths, register reset values, register indexes and error word types.
// ----------------------------------------------------------------------------
`default_nettype none

package edbd_pkg;

	localparam int MaxRowWidthDef = 2048;

	localparam int ChanW     = 8;
	localparam int RowWidthW = 12;
	localparam int WeightW   = 16;
	localparam int ThreshW   = 24;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 24;
	localparam int ErrW      = 10;

	localparam logic [RowWidthW-1:0] RowWidthRst   = 12'd640;
	localparam logic [WeightW-1:0]   RedWeightRst   = 16'd19595;
	localparam logic [WeightW-1:0]   GreenWeightRst = 16'd38470;
	localparam logic [WeightW-1:0]   BlueWeightRst  = 16'd7471;
	localparam logic [ThreshW-1:0]   LumaThreshRst  = 24'd8355840;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ROW_WIDTH      = 3'd0,
		REG_RED_WEIGHT     = 3'd1,
		REG_GREEN_WEIGHT   = 3'd2,
		REG_BLUE_WEIGHT    = 3'd3,
		REG_LUMA_THRESHOLD = 3'd4
	} cfg_reg_t;

	// one signed error lane, and the three lanes of one pixel
	typedef logic signed [ErrW-1:0] err_t;
	typedef logic [2:0][ErrW-1:0] err3_t;

endpackage

`default_nettype wire

[rtl/core/edbd_ifs.sv]
// ----------------------------------------------------------------------------
// edbd_ifs: channel interfaces of the error diffusion binary dither
// Pixel input, result output and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
`default_nettype none

interface edbd_pix_if import edbd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;
	logic             frame_start;

	modport source (output valid, red, green, blue, frame_start, input ready);
	modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface edbd_res_if import edbd_pkg::*; ();
	logic valid;
	logic ready;
	logic white;

	modport source (output valid, white, input ready);
	modport sink (input valid, white, output ready);
endinterface

interface edbd_cfg_if import edbd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/edbd_ram.sv]
// ----------------------------------------------------------------------------
// edbd_ram: generic RAM, one write port, two registered read ports
// Read during write at the same address returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module edbd_ram #(
	parameter int Width = 30,
	parameter int Depth = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_a_en,
	input  logic [$clog2(Depth)-1:0] rd_a_addr,
	output logic [Width-1:0]         rd_a_data,
	input  logic                     rd_b_en,
	input  logic [$clog2(Depth)-1:0] rd_b_addr,
	output logic [Width-1:0]         rd_b_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_data <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_data <= mem[rd_b_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/error_diffusion_binary_dither.sv]
// ----------------------------------------------------------------------------
// error_diffusion_binary_dither: one-bit Floyd-Steinberg dither of RGB pixels
// Pixels arrive in raster order; each gives one result word (1 = white)
// through the stage 1 register and the result register, and a new pixel is
// taken every cycle while the result side keeps up. The rate is set by the
// combinational loop from the right-hand error through clamp, luminance
// multiply and threshold. The row error store is one RAM with one write and
// two read ports; its shares for a column are held in a register and written
// when the next pixel arrives. A frame start clears the store through a fill
// count, so there is no clearing pass. Lowering row_width in the middle of a
// row stalls the next pixel, to write back the held entry.
// ----------------------------------------------------------------------------
`default_nettype none

module error_diffusion_binary_dither import edbd_pkg::*; #(
	parameter int MAX_ROW_WIDTH = MaxRowWidthDef
) (
	input logic        clk,
	input logic        arst_n,
	edbd_cfg_if.sink   cfg,
	edbd_pix_if.sink   pix,
	edbd_res_if.source res
);

	localparam int AW    = $clog2(MAX_ROW_WIDTH);
	localparam int FW    = AW + 1;
	localparam int WW    = (RowWidthW > FW) ? RowWidthW : FW;
	localparam int SumW  = ChanW + 4;
	localparam int ProdW = ChanW + WeightW;
	localparam int LumW  = ProdW + 2;
	localparam int MulW  = ChanW + 5;
	localparam int ShareShift = 4;

	localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};
	localparam logic signed [MulW-1:0] BelowLeftWt = MulW'(3);
	localparam logic signed [MulW-1:0] BelowWt     = MulW'(5);
	localparam logic signed [MulW-1:0] RightWt     = MulW'(7);

	function automatic err_t share16(input logic signed [MulW-1:0] v);
		logic signed [MulW-1:0] q;
		q = v >>> ShareShift;
		return err_t'(ErrW'(q));
	endfunction

	// configuration
	logic [RowWidthW-1:0] row_width_q;
	logic [WeightW-1:0]   red_weight_q;
	logic [WeightW-1:0]   green_weight_q;
	logic [WeightW-1:0]   blue_weight_q;
	logic [ThreshW-1:0]   luma_threshold_q;

	// column tracking
	logic [WW-1:0] row_width_ext;
	logic [WW-1:0] width_eff;
	logic [AW-1:0] col_q;
	logic [AW-1:0] col_acc;
	logic          jump;
	logic          last_acc;
	logic          pix_acc;
	logic          flush;
	logic          flush_hold;

	// stage 1
	logic                 vld_s1;
	logic [2:0][ChanW-1:0] px_s1;
	logic                 fs_s1;
	logic [AW-1:0]        col_s1;
	logic                 last_s1;
	logic                 byp_hit_s1;
	err3_t                byp_data_s1;
	logic                 s1_adv;
	logic [AW-1:0]        col_m1;

	// error state
	err3_t         right_q;
	err3_t         pend_q;
	err3_t         below_acc_q;
	logic [AW-1:0] below_col_q;
	logic          below_vld_q;
	logic [FW-1:0] fill_q;

	// RAM ports
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	err3_t         wr_data;
	err3_t         rd_a;
	err3_t         rd_b;

	// datapath
	logic                  held_hit;
	err3_t                 nre;
	err3_t                 rmw_base;
	err3_t                 re;
	err3_t                 pb;
	logic signed [SumW-1:0] sum [3];
	logic [2:0][ChanW-1:0] clip;
	logic [ProdW-1:0]      prod_r;
	logic [ProdW-1:0]      prod_g;
	logic [ProdW-1:0]      prod_b;
	logic [LumW-1:0]       lum;
	logic                  white;
	logic signed [ChanW:0] err9 [3];
	logic signed [MulW-1:0] err_ext [3];
	err3_t                 wr_lane;
	err3_t                 below_nxt;
	err3_t                 right_nxt;
	err3_t                 pend_nxt;
	logic                  s1_wr;
	logic [AW-1:0]         s1_wr_addr;
	err3_t                 s1_wr_data;

	// output register
	logic out_vld_q;
	logic white_q;

	// ------------------------------------------------------------------
	// register writes
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q      <= RowWidthRst;
			red_weight_q     <= RedWeightRst;
			green_weight_q   <= GreenWeightRst;
			blue_weight_q    <= BlueWeightRst;
			luma_threshold_q <= LumaThreshRst;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ROW_WIDTH:      row_width_q      <= cfg.data[RowWidthW-1:0];
				REG_RED_WEIGHT:     red_weight_q     <= cfg.data[WeightW-1:0];
				REG_GREEN_WEIGHT:   green_weight_q   <= cfg.data[WeightW-1:0];
				REG_BLUE_WEIGHT:    blue_weight_q    <= cfg.data[WeightW-1:0];
				REG_LUMA_THRESHOLD: luma_threshold_q <= cfg.data[ThreshW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// column of the incoming pixel; independent of the pixel data
	// ------------------------------------------------------------------
	always_comb begin
		row_width_ext = WW'(row_width_q);
		priority if (row_width_ext == '0) begin
			width_eff = WW'(1);
		end else if (row_width_ext > WW'(MAX_ROW_WIDTH)) begin
			width_eff = WW'(MAX_ROW_WIDTH);
		end else begin
			width_eff = row_width_ext;
		end
	end

	assign jump = WW'(col_q) >= width_eff;

	always_comb begin
		priority if (pix.frame_start) begin
			col_acc = '0;
		end else if (jump) begin
			col_acc = AW'(width_eff - WW'(1));
		end else begin
			col_acc = col_q;
		end
	end

	assign last_acc = (WW'(col_acc) + WW'(1)) >= width_eff;

	// a shortened row must write back the held entry before the next pixel
	assign flush_hold = jump && (below_vld_q || vld_s1);
	assign flush      = jump && below_vld_q && !vld_s1;

	assign s1_adv    = vld_s1 && (!out_vld_q || res.ready);
	assign pix.ready = (!vld_s1 || s1_adv) && !flush_hold;
	assign pix_acc   = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (pix_acc) begin
				col_q <= last_acc ? '0 : AW'(col_acc + AW'(1));
			end
			if (pix_acc) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload; catch a write that lands on the edge of the read
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			px_s1       <= {pix.red, pix.green, pix.blue};
			fs_s1       <= pix.frame_start;
			col_s1      <= col_acc;
			last_s1     <= last_acc;
			byp_hit_s1  <= wr_en && (wr_addr == col_acc);
			byp_data_s1 <= wr_data;
		end
	end

	// ------------------------------------------------------------------
	// row error store
	// ------------------------------------------------------------------
	edbd_ram #(
		.Width ($bits(err3_t)),
		.Depth (MAX_ROW_WIDTH)
	) u_row_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_a_en   (pix_acc),
		.rd_a_addr (col_acc),
		.rd_a_data (rd_a),
		.rd_b_en   (pix_acc),
		.rd_b_addr (AW'(col_acc - AW'(1))),
		.rd_b_data (rd_b)
	);

	// ------------------------------------------------------------------
	// stage 1 datapath
	// ------------------------------------------------------------------
	assign col_m1   = AW'(col_s1 - AW'(1));
	assign held_hit = below_vld_q && (below_col_q == col_s1);

	always_comb begin
		priority if (fs_s1) begin
			nre = '0;
		end else if (held_hit) begin
			nre = below_acc_q;
		end else if (byp_hit_s1) begin
			nre = byp_data_s1;
		end else if (FW'(col_s1) < fill_q) begin
			nre = rd_a;
		end else begin
			nre = '0;
		end

		// the left-below entry is re-read from RAM only when no entry is held, after reset or a write-back
		priority if (below_vld_q) begin
			rmw_base = below_acc_q;
		end else if (FW'(col_m1) < fill_q) begin
			rmw_base = rd_b;
		end else begin
			rmw_base = '0;
		end

		re = fs_s1 ? '0 : right_q;
		pb = fs_s1 ? '0 : pend_q;
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = $signed({{(SumW-ChanW){1'b0}}, px_s1[c]})
				+ SumW'($signed(re[c])) + SumW'($signed(nre[c]));
			if (sum[c] < 0) begin
				clip[c] = '0;
			end else if (sum[c] > $signed(SumW'(ChanMax))) begin
				clip[c] = ChanMax;
			end else begin
				clip[c] = sum[c][ChanW-1:0];
			end
		end
	end

	// lane 2 is red, lane 1 green, lane 0 blue
	assign prod_r = ProdW'(clip[2]) * ProdW'(red_weight_q);
	assign prod_g = ProdW'(clip[1]) * ProdW'(green_weight_q);
	assign prod_b = ProdW'(clip[0]) * ProdW'(blue_weight_q);
	assign lum    = LumW'(prod_r) + LumW'(prod_g) + LumW'(prod_b);
	assign white  = lum >= LumW'(luma_threshold_q);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (white) begin
				err9[c] = $signed({1'b0, clip[c]}) - $signed({1'b0, ChanMax});
			end else begin
				err9[c] = $signed({1'b0, clip[c]});
			end
			err_ext[c]   = MulW'(err9[c]);
			wr_lane[c]   = ErrW'($signed(rmw_base[c]) + share16(err_ext[c] * BelowLeftWt));
			below_nxt[c] = ErrW'($signed(pb[c]) + share16(err_ext[c] * BelowWt));
			right_nxt[c] = last_s1 ? '0 : ErrW'(share16(err_ext[c] * RightWt));
			pend_nxt[c]  = last_s1 ? '0 : ErrW'(share16(err_ext[c]));
		end
	end

	// each pixel completes the entry left of it, or at a row start the
	// held entry of the row's last column
	always_comb begin
		priority if (col_s1 != '0) begin
			s1_wr      = 1'b1;
			s1_wr_addr = col_m1;
			s1_wr_data = wr_lane;
		end else begin
			s1_wr      = below_vld_q && !fs_s1;
			s1_wr_addr = below_col_q;
			s1_wr_data = below_acc_q;
		end

		priority if (flush) begin
			wr_en   = 1'b1;
			wr_addr = below_col_q;
			wr_data = below_acc_q;
		end else begin
			wr_en   = s1_adv && s1_wr;
			wr_addr = s1_wr_addr;
			wr_data = s1_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q     <= '0;
			pend_q      <= '0;
			below_vld_q <= 1'b0;
			fill_q      <= '0;
		end else if (s1_adv) begin
			right_q     <= right_nxt;
			pend_q      <= pend_nxt;
			below_vld_q <= 1'b1;
			if (fs_s1) begin
				fill_q <= FW'(1);
			end else if (FW'(col_s1) >= fill_q) begin
				fill_q <= FW'(col_s1) + FW'(1);
			end
		end else if (flush) begin
			below_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			below_acc_q <= below_nxt;
			below_col_q <= col_s1;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			white_q <= white;
		end
	end

	assign res.valid = out_vld_q;
	assign res.white = white_q;

`ifndef NO_ASSERTIONS
	// the held entry always lies inside the part of the store filled this frame
	a_held_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		below_vld_q |-> (FW'(below_col_q) < fill_q))
		else $error("held row entry beyond fill count");

	// no RAM write goes past the filled prefix
	a_write_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (FW'(wr_addr) < fill_q))
		else $error("row store written beyond fill count");

	// a pixel past column zero follows the held entry directly
	a_held_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (col_s1 != '0) && below_vld_q |-> (below_col_q == col_m1))
		else $error("held entry is not left of the current pixel");
`endif

endmodule

`default_nettype wire
